/* hw/rtl/fit_pkg.sv */
`default_nettype none
package fit_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int CNT_W        = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [0:0] {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // per-cycle control from the sequencer to every cell
  typedef struct packed {
    logic add;    // apply an add beat
    logic swap;   // odd-even transposition step
    logic phase;  // 0: pairs (0,1),(2,3).. ; 1: pairs (1,2),(3,4)..
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/fit_cell.sv */
`default_nettype none
module fit_cell #(
  parameter int KEY_BITS = fit_pkg::KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fit_pkg::cell_ctrl_t       ctrl,
  input  wire logic [KEY_BITS-1:0]       add_key,
  input  wire logic [fit_pkg::CNT_W-1:0] goff,
  // claim chain: high when a lower cell is free and so has first claim on the key
  input  wire logic                      claim_in,
  output logic                           claim_out,
  input  wire logic                      match_any,
  output logic                           match,
  // neighbors for the sort
  input  wire logic [KEY_BITS-1:0]       lo_key,
  input  wire logic                      lo_used,
  input  wire logic [fit_pkg::CNT_W-1:0] lo_cnt,
  input  wire logic [fit_pkg::CNT_W-1:0] lo_off,
  input  wire logic [KEY_BITS-1:0]       hi_key,
  input  wire logic                      hi_used,
  input  wire logic [fit_pkg::CNT_W-1:0] hi_cnt,
  input  wire logic [fit_pkg::CNT_W-1:0] hi_off,
  input  wire logic                      has_lo,
  input  wire logic                      has_hi,
  output logic [KEY_BITS-1:0]            key,
  output logic                           used,
  output logic [fit_pkg::CNT_W-1:0]      cnt,
  output logic [fit_pkg::CNT_W-1:0]      off
);
  import fit_pkg::*;
  logic free, take, is_left, partner, do_swap;
  logic [CNT_W-1:0] w_me, w_lo, w_hi;

  assign match     = used && key == add_key;
  assign free      = cnt == goff;
  assign take      = free && !claim_in && !match_any;
  assign claim_out = claim_in || free;
  assign w_me = cnt - off;
  assign w_lo = lo_cnt - lo_off;
  assign w_hi = hi_cnt - hi_off;
  // left cell of a pair has even index on phase 0, odd on phase 1
  assign is_left = (IDX % 2 == 0) ? !ctrl.phase : ctrl.phase;
  assign partner = is_left ? has_hi : has_lo;
  assign do_swap = ctrl.swap && partner && (is_left ? (w_me < w_hi) : (w_lo < w_me));

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; used <= 1'b0; cnt <= '0; off <= '0;
    end else if (ctrl.add) begin
      if (match) begin
        cnt <= sat_inc(cnt);
      end else if (take) begin
        key <= add_key; used <= 1'b1; cnt <= sat_inc(goff); off <= goff;
      end
    end else if (do_swap) begin
      if (is_left) begin
        key <= hi_key; used <= hi_used; cnt <= hi_cnt; off <= hi_off;
      end else begin
        key <= lo_key; used <= lo_used; cnt <= lo_cnt; off <= lo_off;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/frequent_items_tracker_unit.sv */
`default_nettype none
// Misra-Gries heavy-hitter table held in a row of ENTRIES cells. On an add beat
// (command 0) every cell compares the key at once, and a claim chain picks the
// lowest slot whose count equals the global offset; otherwise the offset bumps.
// Adds give no result. A read beat (command 1) with no add since the last sort
// reads the row directly. After any add it first runs an odd-even transposition
// sort between neighbor cells, which holds the input off: ENTRIES rounds, then
// one round that finds nothing to swap and reads the result. The sort orders by
// count minus offset, descending, and it is stable because only strictly smaller
// pairs swap. The result is then registered and held until taken. The next item
// can be accepted at the edge that takes the result.
module frequent_items_tracker_unit #(
  parameter int ENTRIES  = fit_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = fit_pkg::KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [31:0] key,
  input  wire logic [7:0]  rank,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      found_key,
  output logic             key_valid
);
  import fit_pkg::*;
  localparam int SW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_SORT = 2'b10} state_t;
  state_t state;
  logic clean, phase;
  logic [SW-1:0] steps;
  logic [7:0] rank_q;
  logic [CNT_W-1:0] goff;
  logic [KEY_BITS-1:0] k_in;
  cell_ctrl_t ctrl;

  logic [KEY_BITS-1:0] c_key [ENTRIES];
  logic                c_used[ENTRIES];
  logic [CNT_W-1:0]    c_cnt [ENTRIES];
  logic [CNT_W-1:0]    c_off [ENTRIES];
  logic                c_match[ENTRIES];
  logic [ENTRIES:0]    claim;
  logic                match_any, acc, rd_now;

  assign k_in = KEY_BITS'(key);
  // a held result frees its register at the edge that takes it
  assign in_ready = state == S_IDLE && (!out_valid || out_ready);
  assign acc = in_valid && in_ready;
  assign claim[0] = 1'b0;
  always_comb begin
    match_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) match_any = match_any | c_match[i];
  end
  assign ctrl.add   = acc && command == CMD_ADD;
  assign ctrl.swap  = state == S_SORT;
  assign ctrl.phase = phase;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam int LO = (g == 0) ? 0 : g - 1;
    localparam int HI = (g == ENTRIES - 1) ? g : g + 1;
    fit_cell #(.KEY_BITS(KEY_BITS), .IDX(g)) u_cell (
      .clk, .rst, .ctrl, .add_key(k_in), .goff,
      .claim_in(claim[g]), .claim_out(claim[g+1]),
      .match_any, .match(c_match[g]),
      .lo_key(c_key[LO]), .lo_used(c_used[LO]), .lo_cnt(c_cnt[LO]), .lo_off(c_off[LO]),
      .hi_key(c_key[HI]), .hi_used(c_used[HI]), .hi_cnt(c_cnt[HI]), .hi_off(c_off[HI]),
      .has_lo(g != 0), .has_hi(g != ENTRIES - 1),
      .key(c_key[g]), .used(c_used[g]), .cnt(c_cnt[g]), .off(c_off[g])
    );
  end

  // read finishes from IDLE when clean, or on the last sort step
  assign rd_now = (acc && command == CMD_READ && clean) ||
                  (state == S_SORT && steps == SW'(ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; clean <= 1'b1; goff <= '0; out_valid <= 1'b0;
      phase <= 1'b0; steps <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            rank_q <= rank;
            if (command == CMD_ADD) begin
              clean <= 1'b0;
              if (!match_any && !claim[ENTRIES]) goff <= sat_inc(goff);
            end else if (!clean) begin
              state <= S_SORT; phase <= 1'b0; steps <= '0;
            end
          end
        end
        S_SORT: begin
          phase <= !phase;
          steps <= steps + 1'b1;
          if (steps == SW'(ENTRIES)) begin
            state <= S_IDLE; clean <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rd_now) out_valid <= 1'b1;
    end
  end

  // result picked from the row; in SORT the last step is a no-op read slot
  logic [7:0] r_sel;
  logic [31:0] sel_key;
  logic sel_valid;
  assign r_sel = (state == S_IDLE) ? rank : rank_q;
  always_comb begin
    sel_key = '0; sel_valid = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (r_sel == 8'(i) && c_used[i]) begin
        sel_key = 32'(c_key[i]); sel_valid = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rd_now) begin
      found_key <= sel_key; key_valid <= sel_valid;
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
  import fit_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [31:0] key = '0;
  logic [7:0] rank = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] found_key;
  logic key_valid;

  frequent_items_tracker_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .key(key), .rank(rank), .out_valid(out_valid),
    .out_ready(out_ready), .found_key(found_key), .key_valid(key_valid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow of the heavy-hitter table
  logic [31:0] t_key [NSLOT];
  logic        t_used [NSLOT];
  logic [31:0] t_cnt [NSLOT];
  logic [31:0] t_off [NSLOT];
  logic [31:0] g_off;
  logic        sorted;

  typedef struct {
    logic [31:0] k;
    logic        v;
  } lookup_t;
  lookup_t pending_reads[$];

  int errors = 0;
  int cycles = 0;
  int in_idle_pct = 24;
  int out_idle_pct = 73;

  function automatic logic [31:0] inc_sat(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < NSLOT; i++) begin
      t_key[i] = '0; t_used[i] = 1'b0; t_cnt[i] = '0; t_off[i] = '0;
    end
    g_off = '0;
    sorted = 1'b1;
  endfunction

  function automatic void table_add(logic [31:0] k);
    int slot;
    slot = -1;
    sorted = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (t_used[i] && t_key[i] == k) begin
        t_cnt[i] = inc_sat(t_cnt[i]);
        return;
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (slot < 0 && t_cnt[i] == g_off) slot = i;
    end
    if (slot >= 0) begin
      t_key[slot] = k; t_used[slot] = 1'b1;
      t_cnt[slot] = inc_sat(g_off); t_off[slot] = g_off;
    end else begin
      g_off = inc_sat(g_off);
    end
  endfunction

  // stable, descending by count minus remembered offset
  function automatic void table_sort();
    logic [31:0] k, c, o, w;
    logic u;
    int j;
    for (int i = 1; i < NSLOT; i++) begin
      k = t_key[i]; u = t_used[i]; c = t_cnt[i]; o = t_off[i]; w = c - o;
      j = i - 1;
      while (j >= 0 && (t_cnt[j] - t_off[j]) < w) begin
        t_key[j+1] = t_key[j]; t_used[j+1] = t_used[j];
        t_cnt[j+1] = t_cnt[j]; t_off[j+1] = t_off[j];
        j--;
      end
      t_key[j+1] = k; t_used[j+1] = u; t_cnt[j+1] = c; t_off[j+1] = o;
    end
    sorted = 1'b1;
  endfunction

  function automatic lookup_t table_read(logic [7:0] r);
    lookup_t res;
    if (!sorted) table_sort();
    res.k = '0; res.v = 1'b0;
    if (r < NSLOT && t_used[r]) begin
      res.k = t_key[r]; res.v = 1'b1;
    end
    return res;
  endfunction

  // input side: predict on acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (cmd_t'(command) == CMD_ADD) table_add(key);
      else pending_reads.push_back(table_read(rank));
    end
  end

  // output side: compare against oldest expected lookup
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result key=%h valid=%b", $time, found_key, key_valid);
        errors++;
      end else begin
        lookup_t e;
        e = pending_reads.pop_front();
        if (e.k !== found_key || e.v !== key_valid) begin
          $display("%0t: mismatch expected key=%h valid=%b actual key=%h valid=%b",
                   $time, e.k, e.v, found_key, key_valid);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic c, logic [31:0] k, logic [7:0] r);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; command <= c; key <= k; rank <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // directed rows; check_static checks the rows whose result is obvious from the spec
  typedef struct {
    logic        c;
    logic [31:0] k;
    logic [7:0]  r;
  } row_t;

  row_t rows[] = '{
    '{CMD_READ, 32'h0, 8'd0},            // empty table: invalid
    '{CMD_READ, 32'h0, 8'd255},          // rank far out of range
    '{CMD_ADD,  32'h0, 8'd0},
    '{CMD_ADD,  32'hFFFF_FFFF, 8'hFF},
    '{CMD_ADD,  32'hFFFF_FFFF, 8'd0},
    '{CMD_READ, 32'hFFFF_FFFF, 8'd0},    // most frequent key
    '{CMD_READ, 32'h0, 8'd1},
    '{CMD_READ, 32'h0, 8'd2},            // empty slot
    '{CMD_READ, 32'h0, 8'd15},
    '{CMD_READ, 32'h0, 8'd16},           // first out-of-range rank
    '{CMD_ADD,  32'hA5A5_5A5A, 8'd0},
    '{CMD_ADD,  32'h5A5A_A5A5, 8'd0},
    '{CMD_READ, 32'h0, 8'd0},
    '{CMD_READ, 32'h0, 8'd0}             // read with no add since last sort
  };

  function automatic void check_static(int idx);
    lookup_t e;
    e = pending_reads[pending_reads.size()-1];
    if ((idx == 0 || idx == 1 || idx == 7 || idx == 9) && (e.v !== 1'b0 || e.k !== 0)) begin
      $display("%0t: directed row %0d expected key=%h valid=%b actual key=%h valid=%b",
               $time, idx, 32'h0, 1'b0, e.k, e.v);
      errors++;
    end
    if (idx == 5 && (e.v !== 1'b1 || e.k !== 32'hFFFF_FFFF)) begin
      $display("%0t: directed row %0d expected key=%h valid=%b actual key=%h valid=%b",
               $time, idx, 32'hFFFF_FFFF, 1'b1, e.k, e.v);
      errors++;
    end
  endfunction

  task automatic random_run(int n);
    logic [31:0] pool [8];
    logic [31:0] k;
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        send_beat(CMD_READ, $urandom, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                                : 8'($urandom_range(NSLOT-1)));
      end else begin
        // skewed stream: hot keys plus many distinct cold ones
        case ($urandom_range(3))
          0, 1: k = pool[$urandom_range(2)];
          2: k = pool[$urandom_range(7)];
          default: k = $urandom;
        endcase
        send_beat(CMD_ADD, k, 8'($urandom));
      end
      if ($urandom_range(3) == 0) drop_valid();
    end
    drop_valid();
  endtask

  task automatic drain();
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    table_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_beat(rows[i].c, rows[i].k, rows[i].r);
      if (rows[i].c == CMD_READ) begin
        @(negedge clk);
        check_static(i);
      end
    end
    // many distinct keys to fill the table and push the global offset
    for (int i = 0; i < 20; i++) send_beat(CMD_ADD, 32'(32'h1000 + i), 8'd0);
    for (int r = 0; r < NSLOT + 1; r++) send_beat(CMD_READ, 32'h0, 8'(r));
    drop_valid();

    random_run(130);
    drain();
    in_idle_pct = 73; out_idle_pct = 24;
    random_run(130);
    drain();
    in_idle_pct = 0; out_idle_pct = 0;
    random_run(130);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/fit_pkg.sv
hw/rtl/fit_cell.sv
hw/rtl/frequent_items_tracker_unit.sv
tb/tb.sv
